// ===== hw/rtl/rgb_strip_button_pairing_control_macros.svh =====
// Assertion macros for the controller RTL.
`ifndef RGB_STRIP_BUTTON_PAIRING_CONTROL_MACROS_SVH
`define RGB_STRIP_BUTTON_PAIRING_CONTROL_MACROS_SVH

`ifndef SYNTH

// Checked on every rising clock edge outside reset.
`define RSBP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication form, checked outside reset.
`define RSBP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define RSBP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RSBP_ASSERT(name, clk, rst_n, prop)
`define RSBP_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define RSBP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/rgbsbp_pkg.sv =====
`default_nettype none

package rgbsbp_pkg;

  typedef enum logic [1:0] {
    OpButton   = 2'd0,
    OpTick     = 2'd1,
    OpColor    = 2'd2,
    OpPairDone = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CfgInitialColor = 2'd0;
  localparam logic [1:0] CfgLongPress    = 2'd1;
  localparam logic [1:0] CfgShortPress   = 2'd2;

  localparam int unsigned ColorW = 24;
  localparam int unsigned CmdW   = 32;

  localparam logic [ColorW-1:0] PairBright   = 24'h00A000;
  localparam logic [ColorW-1:0] PairDim      = 24'h001000;
  localparam logic [ColorW-1:0] ResetColor   = 24'h808080;
  localparam logic [CmdW-1:0]   CmdOn        = 32'hFFFF_FFFF;
  localparam logic [CmdW-1:0]   CmdOff       = 32'h0000_0000;
  localparam logic [7:0]        ResetLong    = 8'd30;
  localparam logic [7:0]        ResetShort   = 8'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_strip_button_pairing_control.sv =====
// A result passes through the input register, then the result register, before
//   it is offered on the result channel; a stall on that channel holds it.
// Throughput: one input transaction per cycle, sustained while the result
//   channel does not stall; a held result still lets one item enter an empty
//   input register, then the input stalls.
// Reset (rst_ni low, asynchronous): pipeline empty, queue empty, not pairing,
//   strip on, blink bright, stored color 0x808080, press thresholds 30 and 3.
`default_nettype none
`include "rgb_strip_button_pairing_control_macros.svh"

module rgb_strip_button_pairing_control
  import rgbsbp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        op_i,
  input  wire logic              button_pressed_i,
  input  wire logic [CmdW-1:0]   command_value_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   drive_valid_o,
  output logic [7:0]             red_level_o,
  output logic [7:0]             green_level_o,
  output logic [7:0]             blue_level_o,
  output logic                   report_valid_o,
  output logic [ColorW-1:0]      report_value_o,
  output logic                   save_request_o,
  output logic                   pairing_active_o,
  output logic                   queue_overflow_o,
  // configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [ColorW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] QueueFull = CntW'(QUEUE_DEPTH);

  // ---------------------------------------------------------------------------
  // Handshake. The input register holds one item; it moves into the result
  // register when that register is empty or being drained this cycle.
  // ---------------------------------------------------------------------------
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready;
  logic advance;
  logic in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // Config is always taken; the user must write it only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  // input payload register
  op_e             op_q;
  logic            pressed_q;
  logic [CmdW-1:0] cmd_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q      <= op_e'(op_i);
      pressed_q <= button_pressed_i;
      cmd_q     <= command_value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  logic [7:0]        press_count_q, press_count_d;
  logic              pairing_q, pairing_d;
  logic              strip_on_q, strip_on_d;
  logic              blink_bright_q, blink_bright_d;
  logic [ColorW-1:0] stored_color_q, stored_color_d;
  logic [7:0]        long_ticks_q, long_ticks_d;
  logic [7:0]        short_ticks_q, short_ticks_d;
  logic [CntW-1:0]   fifo_count_q, fifo_count_d;

  // Command queue as a shift line: entry 0 is always the head, a push lands
  // at the current fill level, a pop shifts every entry down by one.
  logic [CmdW-1:0]   fifo_q [QUEUE_DEPTH];

  // per-item decisions
  logic              push_req;
  logic [CmdW-1:0]   push_val;
  logic              push_ok;
  logic              pop;
  logic              queue_full;

  // result fields
  logic              drive_d;
  logic [ColorW-1:0] color_d;
  logic              report_d;
  logic [ColorW-1:0] rep_d;
  logic              save_d;
  logic              ovf_d;

  assign queue_full = (fifo_count_q == QueueFull);

  always_comb begin
    press_count_d  = press_count_q;
    pairing_d      = pairing_q;
    strip_on_d     = strip_on_q;
    blink_bright_d = blink_bright_q;
    stored_color_d = stored_color_q;
    push_req       = 1'b0;
    push_val       = CmdOn;
    pop            = 1'b0;
    drive_d        = 1'b0;
    color_d        = '0;
    report_d       = 1'b0;
    rep_d          = '0;
    save_d         = 1'b0;

    if (advance) begin
      unique case (op_q)
        OpButton: begin
          if (pressed_q) begin
            // saturating press counter
            if (press_count_q < long_ticks_q) begin
              press_count_d = press_count_q + 8'd1;
            end
          end else begin
            if (press_count_q >= long_ticks_q && !pairing_q) begin
              pairing_d = 1'b1;
            end else if (press_count_q > short_ticks_q) begin
              if (pairing_q) begin
                // a press past the short threshold while pairing ends it and queues a strip-on command
                push_req  = 1'b1;
                push_val  = CmdOn;
                pairing_d = 1'b0;
              end else begin
                strip_on_d = !strip_on_q;
                push_req   = 1'b1;
                push_val   = strip_on_q ? CmdOff : CmdOn;
                report_d   = 1'b1;
                rep_d      = strip_on_q ? '0 : ColorW'(1);
              end
            end
            press_count_d = '0;
          end
        end
        OpTick: begin
          if (pairing_q) begin
            drive_d        = 1'b1;
            color_d        = blink_bright_q ? PairBright : PairDim;
            blink_bright_d = !blink_bright_q;
          end else if (fifo_count_q != '0) begin
            pop     = 1'b1;
            drive_d = 1'b1;
            if (fifo_q[0] == CmdOn) begin
              color_d  = stored_color_q;
              report_d = 1'b1;
              rep_d    = stored_color_q;
            end else if (fifo_q[0] == CmdOff) begin
              report_d = 1'b1;
            end else begin
              // top byte ignored; a zero color still gets stored and saved
              color_d        = fifo_q[0][ColorW-1:0];
              stored_color_d = fifo_q[0][ColorW-1:0];
              save_d         = 1'b1;
            end
          end
        end
        OpColor: begin
          push_req = 1'b1;
          push_val = cmd_q;
        end
        OpPairDone: begin
          push_req  = 1'b1;
          push_val  = CmdOn;
          pairing_d = 1'b0;
        end
      endcase
    end

    // writing initial_color loads the stored color at once
    if (cfg_valid_i && cfg_ready_o && cfg_index_i == CfgInitialColor) begin
      stored_color_d = cfg_data_i;
    end
  end

  assign push_ok = push_req && !queue_full;
  assign ovf_d   = push_req && queue_full;

  always_comb begin
    fifo_count_d = fifo_count_q;
    if (push_ok) begin
      fifo_count_d = fifo_count_q + CntW'(1);
    end else if (pop) begin
      fifo_count_d = fifo_count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push_ok && fifo_count_q == CntW'(i)) begin
        fifo_q[i] <= push_val;
      end else if (pop && i < QUEUE_DEPTH - 1) begin
        fifo_q[i] <= fifo_q[(i + 1) % QUEUE_DEPTH];
      end
    end
  end

  // configuration decode for the press thresholds
  always_comb begin
    long_ticks_d  = long_ticks_q;
    short_ticks_d = short_ticks_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgLongPress:  long_ticks_d  = cfg_data_i[7:0];
        CfgShortPress: short_ticks_d = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      press_count_q  <= '0;
      pairing_q      <= 1'b0;
      strip_on_q     <= 1'b1;
      blink_bright_q <= 1'b1;
      stored_color_q <= ResetColor;
      long_ticks_q   <= ResetLong;
      short_ticks_q  <= ResetShort;
      fifo_count_q   <= '0;
    end else begin
      in_valid_q     <= in_valid_d;
      out_valid_q    <= out_valid_d;
      press_count_q  <= press_count_d;
      pairing_q      <= pairing_d;
      strip_on_q     <= strip_on_d;
      blink_bright_q <= blink_bright_d;
      stored_color_q <= stored_color_d;
      long_ticks_q   <= long_ticks_d;
      short_ticks_q  <= short_ticks_d;
      fifo_count_q   <= fifo_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic              drive_q;
  logic [ColorW-1:0] color_q;
  logic              report_q;
  logic [ColorW-1:0] rep_q;
  logic              save_q;
  logic              pairing_out_q;
  logic              ovf_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q       <= drive_d;
      color_q       <= color_d;
      report_q      <= report_d;
      rep_q         <= rep_d;
      save_q        <= save_d;
      pairing_out_q <= pairing_d;
      ovf_q         <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_valid_o    = drive_q;
  assign red_level_o      = color_q[23:16];
  assign green_level_o    = color_q[15:8];
  assign blue_level_o     = color_q[7:0];
  assign report_valid_o   = report_q;
  assign report_value_o   = rep_q;
  assign save_request_o   = save_q;
  assign pairing_active_o = pairing_out_q;
  assign queue_overflow_o = ovf_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RSBP_ASSERT(a_fifo_bound, clk_i, rst_ni, fifo_count_q <= QueueFull)
  `RSBP_ASSERT_NEXT(a_ovf_keeps_count, clk_i, rst_ni, advance && ovf_d, $stable(fifo_count_q))
  `RSBP_ASSERT_NEXT(a_pairing_out_tracks, clk_i, rst_ni, advance, pairing_out_q == pairing_q)
  `RSBP_ASSERT_IMPL(a_no_drive_dark, clk_i, rst_ni, out_valid_q && !drive_q, color_q == '0)
  `RSBP_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop, fifo_count_q != '0)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Regression for the LED strip controller: button press counting, pairing mode,
// the color command queue and its overflow flag. Event transactions come from a
// backlog queue that the stimulus thread fills. A shadow of the controller
// state predicts one response per accepted event. Responses are compared field
// by field, in order.
module tb;
  import rgbsbp_pkg::*;

  localparam int QueueDepth  = 5;
  localparam int DrainCycles = 4;     // two pipeline stages plus margin
  localparam int StallLimit  = 2000;  // idle cycles before the run is declared hung
  localparam int IdlePct     = 26;

  typedef struct {
    op_e         kind;
    logic        pressed;
    logic [31:0] value;
  } strip_event_t;

  typedef struct packed {
    logic              drive;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              report;
    logic [ColorW-1:0] rep;
    logic              save;
    logic              pairing;
    logic              ovf;
  } strip_result_t;

  // DUT connections; every input starts at a known value.
  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [1:0]        op_i             = '0;
  logic              button_pressed_i = 1'b0;
  logic [CmdW-1:0]   command_value_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic              drive_valid_o;
  logic [7:0]        red_level_o;
  logic [7:0]        green_level_o;
  logic [7:0]        blue_level_o;
  logic              report_valid_o;
  logic [ColorW-1:0] report_value_o;
  logic              save_request_o;
  logic              pairing_active_o;
  logic              queue_overflow_o;
  logic              cfg_valid_i      = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i      = '0;
  logic [ColorW-1:0] cfg_data_i       = '0;

  rgb_strip_button_pairing_control #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .button_pressed_i (button_pressed_i),
    .command_value_i  (command_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_valid_o    (drive_valid_o),
    .red_level_o      (red_level_o),
    .green_level_o    (green_level_o),
    .blue_level_o     (blue_level_o),
    .report_valid_o   (report_valid_o),
    .report_value_o   (report_value_o),
    .save_request_o   (save_request_o),
    .pairing_active_o (pairing_active_o),
    .queue_overflow_o (queue_overflow_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the controller: thresholds, press counter, modes, command queue.
  // ---------------------------------------------------------------------------
  logic [7:0]        long_ticks   = ResetLong;
  logic [7:0]        short_ticks  = ResetShort;
  logic [ColorW-1:0] stored_color = ResetColor;
  logic [7:0]        press_cnt    = '0;
  logic              pairing      = 1'b0;
  logic              strip_on     = 1'b1;
  logic              blink_bright = 1'b1;
  logic [CmdW-1:0]   cmd_fifo[$];

  strip_event_t  event_backlog[$];       // events not yet offered to the DUT
  strip_result_t expected_responses[$];  // predicted, not yet seen
  strip_result_t head_resp;

  bit calm = 1'b0;  // set for a phase with no idling on either side
  int mismatches = 0;
  int events_done = 0;
  int responses_checked = 0;
  int overflows_seen = 0;
  int blinks_seen = 0;
  int quiet_cycles = 0;

  // Returns 0 when the queue is full and the command is dropped.
  function automatic logic cmd_push(logic [CmdW-1:0] v);
    if (cmd_fifo.size() >= QueueDepth) return 1'b0;
    cmd_fifo.push_back(v);
    return 1'b1;
  endfunction

  function automatic strip_result_t predict_strip_response(op_e kind, logic pressed,
                                                           logic [CmdW-1:0] value);
    strip_result_t     r;
    logic [CmdW-1:0]   popped;
    logic [ColorW-1:0] color;
    r = '0;
    color = '0;
    case (kind)
      OpButton: begin
        if (pressed) begin
          // saturates at the long press threshold
          if (press_cnt < long_ticks) press_cnt = press_cnt + 8'd1;
        end else begin
          if (press_cnt >= long_ticks && !pairing) begin
            pairing = 1'b1;
          end else if (press_cnt > short_ticks) begin
            if (pairing) begin
              // any press past the short threshold while pairing, long ones too, ends pairing
              r.ovf = !cmd_push(CmdOn);
              pairing = 1'b0;
            end else begin
              // toggle is reported even when its command is dropped
              strip_on = !strip_on;
              r.ovf = !cmd_push(strip_on ? CmdOn : CmdOff);
              r.report = 1'b1;
              r.rep = strip_on ? 24'd1 : 24'd0;
            end
          end
          press_cnt = '0;
        end
      end
      OpTick: begin
        if (pairing) begin
          r.drive = 1'b1;
          color = blink_bright ? PairBright : PairDim;
          blink_bright = !blink_bright;
          blinks_seen++;
        end else if (cmd_fifo.size() > 0) begin
          popped = cmd_fifo.pop_front();
          r.drive = 1'b1;
          if (popped == CmdOn) begin
            color = stored_color;
            r.report = 1'b1;
            r.rep = stored_color;
          end else if (popped == CmdOff) begin
            r.report = 1'b1;
          end else begin
            // top byte ignored; a zero color with a nonzero top byte stores 0
            color = popped[ColorW-1:0];
            stored_color = color;
            r.save = 1'b1;
          end
        end
      end
      OpColor: r.ovf = !cmd_push(value);
      default: begin
        r.ovf = !cmd_push(CmdOn);
        pairing = 1'b0;
      end
    endcase
    r.red     = color[23:16];
    r.green   = color[15:8];
    r.blue    = color[7:0];
    r.pairing = pairing;
    if (r.ovf) overflows_seen++;
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [ColorW-1:0] got, logic [ColorW-1:0] want);
    if (got !== want)
      log_mismatch($sformatf("response %0d %s got %0h want %0h",
                             responses_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers backlog events on the input channel. A new event is loaded
  // only when the channel is empty or the current transaction was accepted, so
  // a stalled payload holds. Valid is decided without looking at stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_responses.push_back(
          predict_strip_response(op_e'(op_i), button_pressed_i, command_value_i));
        events_done++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (event_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          op_i             <= event_backlog[0].kind;
          button_pressed_i <= event_backlog[0].pressed;
          command_value_i  <= event_backlog[0].value;
          void'(event_backlog.pop_front());
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted response against the oldest prediction and
  // throws random stall on the result channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_responses.size() == 0) begin
          log_mismatch("response with no event outstanding");
        end else begin
          head_resp = expected_responses.pop_front();
          check_field("drive_valid", ColorW'(drive_valid_o), ColorW'(head_resp.drive));
          check_field("red_level", ColorW'(red_level_o), ColorW'(head_resp.red));
          check_field("green_level", ColorW'(green_level_o), ColorW'(head_resp.green));
          check_field("blue_level", ColorW'(blue_level_o), ColorW'(head_resp.blue));
          check_field("report_valid", ColorW'(report_valid_o), ColorW'(head_resp.report));
          check_field("report_value",   report_value_o,   head_resp.rep);
          check_field("save_request", ColorW'(save_request_o), ColorW'(head_resp.save));
          check_field("pairing_active", ColorW'(pairing_active_o),
                      ColorW'(head_resp.pairing));
          check_field("queue_overflow", ColorW'(queue_overflow_o), ColorW'(head_resp.ovf));
        end
        responses_checked++;
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Hang detection: no transaction on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("rgb_strip_button_pairing_control regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_event(op_e kind, logic pressed, logic [CmdW-1:0] value);
    strip_event_t ev;
    ev.kind    = kind;
    ev.pressed = pressed;
    ev.value   = value;
    event_backlog.push_back(ev);
  endtask

  // n held samples followed by one release; unused fields carry noise
  task automatic add_press(int n);
    for (int i = 0; i < n; i++) add_event(OpButton, 1'b1, $urandom);
    add_event(OpButton, 1'b0, $urandom);
  endtask

  // Register write; only called with the pipeline empty.
  task automatic cfg_write(logic [1:0] idx, logic [ColorW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgInitialColor: stored_color = data;  // loads the stored color at once
      CfgLongPress:    long_ticks   = data[7:0];
      CfgShortPress:   short_ticks  = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [ColorW-1:0] color, logic [7:0] lng, logic [7:0] sht);
    cfg_write(CfgInitialColor, color);
    cfg_write(CfgLongPress, {16'h0, lng});
    cfg_write(CfgShortPress, {16'h0, sht});
  endtask

  // Sender holds off until every predicted response has come back.
  task automatic settle();
    while (event_backlog.size() != 0 || in_valid_i || expected_responses.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [CmdW-1:0] random_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      return CmdOn;
    else if (pick < 32) return CmdOff;
    else if (pick < 44) return {8'($urandom_range(1, 255)), 24'h0};  // zero color, junk top
    else if (pick < 70) return {8'h00, 24'($urandom)};
    else                return $urandom;
  endfunction

  // Mostly well-formed press sequences sized around the thresholds, mixed with
  // ticks to drain the queue, color commands and pairing completions.
  task automatic add_random_events(int n);
    int added;
    int pick;
    int lim;
    int len;
    added = 0;
    lim = (long_ticks < 10) ? int'(long_ticks) + 2 : 8;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = $urandom_range(0, lim);
        add_press(len);
        added += len + 1;
      end else if (pick < 60) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) add_event(OpTick, 1'($urandom), $urandom);
        added += len;
      end else if (pick < 85) begin
        add_event(OpColor, 1'($urandom), random_command());
        added++;
      end else if (pick < 92) begin
        add_event(OpPairDone, 1'($urandom), $urandom);
        added++;
      end else begin
        // stray sample, possibly a lone release or a press left hanging
        add_event(OpButton, 1'($urandom), $urandom);
        added++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: tiny thresholds so every press kind fits in a few events.
    set_thresholds(24'h123456, 8'd2, 8'd0);
    add_event(OpTick, 1'b0, '0);          // empty queue, not pairing: nothing driven
    add_event(OpButton, 1'b0, '0);        // release with no press: nothing
    add_press(1);                         // short press: strip off, queue off
    add_press(3);                         // held past saturation: enter pairing
    add_event(OpTick, 1'b1, '0);          // bright green
    add_event(OpTick, 1'b0, '1);          // dim green
    add_press(2);                         // long press while pairing ends it
    add_event(OpTick, 1'b0, '0);          // pops off
    add_event(OpTick, 1'b0, '0);          // pops on: stored color, reported
    add_event(OpColor, 1'b0, 32'hAB00_0000);
    add_event(OpColor, 1'b1, 32'h00FF_FFFF);
    add_event(OpColor, 1'b0, 32'h0000_0001);
    add_event(OpPairDone, 1'b0, '0);
    add_event(OpColor, 1'b1, CmdOn);      // queue now full
    add_event(OpColor, 1'b0, 32'h005A_5A5A);  // dropped
    add_press(1);                         // toggle on, dropped but still reported
    for (int i = 0; i < QueueDepth; i++) add_event(OpTick, 1'b0, '0);
    settle();

    set_thresholds(24'hFFFFFF, 8'd6, 8'd2);
    add_random_events(150);
    settle();

    // No idling on either side through this whole phase.
    calm = 1'b1;
    set_thresholds(24'h000000, 8'd0, 8'd0);  // every release while idle pairs
    add_random_events(100);
    settle();
    calm = 1'b0;

    // Largest thresholds: one full-length hold, otherwise short holds.
    set_thresholds(24'hA5C3F0, 8'd255, 8'd254);
    add_press(256);
    add_random_events(40);
    settle();

    set_thresholds(24'h5A3C0F, 8'd9, 8'd4);
    add_random_events(90);
    settle();

    $display("covered %0d events and %0d responses over five threshold settings",
             events_done, responses_checked);
    $display("saw %0d dropped commands and %0d pairing blinks", overflows_seen, blinks_seen);
    if (mismatches == 0)
      $display("rgb_strip_button_pairing_control regression: pass");
    else
      $display("rgb_strip_button_pairing_control regression: fail");
    $finish;
  end

endmodule
